>>> rtl/core/lsa_pkg.sv
// lsa_pkg: shared types and codes for the local sequence aligner
// used by the controller, the datapath, the top level and the checker
`default_nettype none

package lsa_pkg;

    // item actions
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND_A = 2'd1;
    localparam logic [1:0] ACT_APPEND_B = 2'd2;
    localparam logic [1:0] ACT_ALIGN  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam int SCORE_W = 9;
    localparam int PATH_W  = 18;

    // which neighbor of (i, j) the score memory reads
    typedef enum logic [1:0] {
        RD_CUR  = 2'd0,
        RD_LEFT = 2'd1,
        RD_TOP  = 2'd2,
        RD_DIAG = 2'd3
    } rsel_t;

    // controller to datapath commands
    typedef struct packed {
        logic  accept;
        rsel_t rsel;
        logic  fill_wr;
        logic  tb_init;
        logic  cap_left;
        logic  cap_top;
        logic  tb_step;
        logic  emit;
        logic  emit_empty;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic no_cells;
        logic fill_last;
        logic best_zero;
        logic cur_zero;
        logic out_last;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/local_sequence_aligner_core.sv
// local_sequence_aligner_core: top level joining controller and datapath
// depends on lsa_pkg, lsa_ctrl and lsa_datapath
`default_nettype none

// Smith-Waterman local aligner with a linear gap score. start is taken when
// busy is low; clear and append items give no result. An align item fills
// the score matrix cell by cell (one registered read of the upper neighbor,
// then compute and write), then checks the best score, traces back with
// four score memory reads and a decision per step until the closing zero
// cell, then gives each aligned column (path buffer read, then result
// register). Results appear on the output ports for one cycle each, marked by
// strobe, and cannot be held off by the receiver.
// A run with no positive score gives a single result with empty_res and last.
module local_sequence_aligner_core #(
    parameter int MAX_LEN = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] action,
    input  wire logic [7:0] symbol,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_index,
    input  wire logic [3:0] wr_data,
    output logic            strobe,
    output logic [7:0]      a_symbol,
    output logic [7:0]      b_symbol,
    output logic            a_gap,
    output logic            b_gap,
    output logic [8:0]      best_score,
    output logic            empty_res,
    output logic            last
);
    import lsa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lsa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    lsa_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .action     (action),
        .symbol     (symbol),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .strobe     (strobe),
        .a_symbol   (a_symbol),
        .b_symbol   (b_symbol),
        .a_gap      (a_gap),
        .b_gap      (b_gap),
        .best_score (best_score),
        .empty_res  (empty_res),
        .last       (last)
    );

endmodule

`default_nettype wire

>>> rtl/core/lsa_ctrl.sv
// lsa_ctrl: sequencing state machine for fill, traceback and output
// depends on lsa_pkg for the command and status structs
`default_nettype none

module lsa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    action,
    input  wire lsa_pkg::sts_t sts,
    output lsa_pkg::cmd_t      cmd,
    output logic               busy
);
    import lsa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_F_RD   = 12'b000000000010,
        S_F_WR   = 12'b000000000100,
        S_F_DONE = 12'b000000001000,
        S_EMPTY  = 12'b000000010000,
        S_T_CUR  = 12'b000000100000,
        S_T_LEFT = 12'b000001000000,
        S_T_TOP  = 12'b000010000000,
        S_T_DIAG = 12'b000100000000,
        S_T_DEC  = 12'b001000000000,
        S_O_RD   = 12'b010000000000,
        S_O_EM   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.rsel = RD_CUR;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = start;
                if (start && action == ACT_ALIGN)
                begin
                    state_next = sts.no_cells ? S_EMPTY : S_F_RD;
                end
            end
            S_F_RD:
            begin
                cmd.rsel = RD_TOP;
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                cmd.rsel = RD_TOP;
                cmd.fill_wr = 1'b1;
                state_next = sts.fill_last ? S_F_DONE : S_F_RD;
            end
            S_F_DONE:
            begin
                if (sts.best_zero)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    cmd.tb_init = 1'b1;
                    state_next = S_T_CUR;
                end
            end
            S_EMPTY:
            begin
                cmd.emit_empty = 1'b1;
                state_next = S_IDLE;
            end
            S_T_CUR:
            begin
                cmd.rsel = RD_CUR;
                state_next = S_T_LEFT;
            end
            S_T_LEFT:
            begin
                cmd.rsel = RD_LEFT;
                state_next = sts.cur_zero ? S_O_RD : S_T_TOP;
            end
            S_T_TOP:
            begin
                cmd.rsel = RD_TOP;
                cmd.cap_left = 1'b1;
                state_next = S_T_DIAG;
            end
            S_T_DIAG:
            begin
                cmd.rsel = RD_DIAG;
                cmd.cap_top = 1'b1;
                state_next = S_T_DEC;
            end
            S_T_DEC:
            begin
                cmd.rsel = RD_DIAG;
                cmd.tb_step = 1'b1;
                state_next = S_T_CUR;
            end
            S_O_RD:
            begin
                state_next = S_O_EM;
            end
            S_O_EM:
            begin
                cmd.emit = 1'b1;
                state_next = sts.out_last ? S_IDLE : S_O_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/lsa_datapath.sv
// lsa_datapath: sequence stores, score matrix, path buffer and result registers
// depends on lsa_pkg; driven by lsa_ctrl commands
`default_nettype none

module lsa_datapath #(
    parameter int MAX_LEN = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lsa_pkg::cmd_t cmd,
    output lsa_pkg::sts_t      sts,
    input  wire logic [1:0]    action,
    input  wire logic [7:0]    symbol,
    input  wire logic          wr_en,
    input  wire logic [1:0]    wr_index,
    input  wire logic [3:0]    wr_data,
    output logic               strobe,
    output logic [7:0]         a_symbol,
    output logic [7:0]         b_symbol,
    output logic               a_gap,
    output logic               b_gap,
    output logic [8:0]         best_score,
    output logic               empty_res,
    output logic               last
);
    import lsa_pkg::*;

    localparam int DIM   = MAX_LEN + 1;
    localparam int LW    = $clog2(DIM);
    localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SA    = $clog2(DIM * DIM);
    localparam int PDEP  = 2 * MAX_LEN;
    localparam int PA    = $clog2(PDEP);
    localparam int PW    = $clog2(PDEP + 1);

    // configuration registers
    logic [3:0] match_reg, mism_reg, gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 4'd3;
            mism_reg  <= 4'd3;
            gap_reg   <= 4'd2;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MATCH:    match_reg <= wr_data;
                REG_MISMATCH: mism_reg  <= wr_data;
                REG_GAP:      gap_reg   <= wr_data;
                default:      ;
            endcase
        end
    end

    // sequence lengths
    logic [LW-1:0] len_a_reg, len_b_reg;
    logic load_a, load_b;

    assign load_a = cmd.accept && action == ACT_APPEND_A && len_a_reg < LW'(MAX_LEN);
    assign load_b = cmd.accept && action == ACT_APPEND_B && len_b_reg < LW'(MAX_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
        end
        else if (cmd.accept && action == ACT_CLEAR)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
        end
        else
        begin
            if (load_a) len_a_reg <= len_a_reg + LW'(1);
            if (load_b) len_b_reg <= len_b_reg + LW'(1);
        end
    end

    // cell position counters
    logic [LW-1:0] i_reg, j_reg, bi_reg, bj_reg;

    // sequence stores, read at column j-1 and row i-1
    logic [7:0] seq_a_mem [MAX_LEN];
    logic [7:0] seq_b_mem [MAX_LEN];
    logic [7:0] sa_rd_reg, sb_rd_reg;
    logic [LW-1:0] jm1, im1;

    assign jm1 = j_reg - LW'(1);
    assign im1 = i_reg - LW'(1);

    always_ff @(posedge clk)
    begin
        if (load_a) seq_a_mem[len_a_reg[IW-1:0]] <= symbol;
        if (load_b) seq_b_mem[len_b_reg[IW-1:0]] <= symbol;
        sa_rd_reg <= seq_a_mem[jm1[IW-1:0]];
        sb_rd_reg <= seq_b_mem[im1[IW-1:0]];
    end

    // score matrix memory, row-major with row stride DIM
    logic [SCORE_W-1:0] score_mem [DIM*DIM];
    logic [SCORE_W-1:0] score_rd_reg;
    logic [LW-1:0] rrow, rcol;
    logic [SA-1:0] raddr, waddr;
    logic [SCORE_W-1:0] wdata;

    assign rrow  = (cmd.rsel == RD_TOP || cmd.rsel == RD_DIAG) ? im1 : i_reg;
    assign rcol  = (cmd.rsel == RD_LEFT || cmd.rsel == RD_DIAG) ? jm1 : j_reg;
    assign raddr = SA'(rrow) * SA'(DIM) + SA'(rcol);
    assign waddr = SA'(i_reg) * SA'(DIM) + SA'(j_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr) score_mem[waddr] <= wdata;
        score_rd_reg <= score_mem[raddr];
    end

    // neighbor values with the border row and column as zero
    logic [SCORE_W-1:0] left_reg, diag_reg, top_reg;
    logic first_row, first_col;
    logic [SCORE_W-1:0] top_v, left_v, diag_v;

    assign first_row = (i_reg == LW'(1));
    assign first_col = (j_reg == LW'(1));
    assign top_v  = first_row ? '0 : score_rd_reg;
    assign left_v = first_col ? '0 : left_reg;
    assign diag_v = (first_row || first_col) ? '0 : diag_reg;

    // candidate scores
    logic signed [11:0] gain, c_left, c_top, c_diag, c_max, best_s;
    logic signed [SCORE_W+2:0] tl_left, tl_top, tl_diag;

    assign gain = (sa_rd_reg == sb_rd_reg) ? $signed({8'd0, match_reg})
                                           : -$signed({8'd0, mism_reg});
    assign c_left = $signed({3'd0, left_v}) - $signed({8'd0, gap_reg});
    assign c_top  = $signed({3'd0, top_v}) - $signed({8'd0, gap_reg});
    assign c_diag = $signed({3'd0, diag_v}) + gain;
    assign c_max  = (c_diag > ((c_left > c_top) ? c_left : c_top)) ? c_diag
                  : ((c_left > c_top) ? c_left : c_top);

    logic [SCORE_W-1:0] best_reg;
    assign best_s = $signed({3'd0, best_reg});
    assign wdata  = c_max[11] ? '0 : c_max[SCORE_W-1:0];

    // traceback candidates, border neighbors read as zero
    // the diagonal comes straight from the read register during decide
    logic [SCORE_W-1:0] trace_top_v, trace_diag_v;

    assign trace_top_v  = first_row ? '0 : top_reg;
    assign trace_diag_v = (first_row || first_col) ? '0 : score_rd_reg;
    assign tl_left = $signed({3'd0, left_v}) - $signed({8'd0, gap_reg});
    assign tl_top  = $signed({3'd0, trace_top_v}) - $signed({8'd0, gap_reg});
    assign tl_diag = $signed({3'd0, trace_diag_v}) + gain;

    // path buffer
    logic [PATH_W-1:0] path_mem [PDEP];
    logic [PATH_W-1:0] path_rd_reg, path_entry;
    logic [PW-1:0] n_reg, k_reg, ridx;
    logic take_diag, take_left;

    assign take_diag = (tl_diag >= tl_left) && (tl_diag >= tl_top);
    assign take_left = (tl_left >= tl_top);
    assign ridx = n_reg - PW'(1) - k_reg;

    always_comb
    begin
        if (take_diag)
        begin
            path_entry = {2'b00, sb_rd_reg, sa_rd_reg};
        end
        else if (take_left)
        begin
            path_entry = {2'b10, 8'd0, sa_rd_reg};
        end
        else
        begin
            path_entry = {2'b01, sb_rd_reg, 8'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tb_step) path_mem[n_reg[PA-1:0]] <= path_entry;
        path_rd_reg <= path_mem[ridx[PA-1:0]];
    end

    // fill and traceback registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            bi_reg   <= '0;
            bj_reg   <= '0;
            best_reg <= '0;
            n_reg    <= '0;
            k_reg    <= '0;
        end
        else if (cmd.accept && action == ACT_ALIGN)
        begin
            i_reg    <= LW'(1);
            j_reg    <= LW'(1);
            best_reg <= '0;
        end
        else if (cmd.fill_wr)
        begin
            if (c_max > best_s)
            begin
                best_reg <= c_max[SCORE_W-1:0];
                bi_reg   <= i_reg;
                bj_reg   <= j_reg;
            end
            if (j_reg == len_a_reg)
            begin
                j_reg <= LW'(1);
                i_reg <= i_reg + LW'(1);
            end
            else
            begin
                j_reg <= j_reg + LW'(1);
            end
        end
        else if (cmd.tb_init)
        begin
            i_reg <= bi_reg;
            j_reg <= bj_reg;
            n_reg <= '0;
            k_reg <= '0;
        end
        else if (cmd.tb_step)
        begin
            n_reg <= n_reg + PW'(1);
            if (take_diag || take_left) j_reg <= jm1;
            if (!take_left || take_diag) i_reg <= im1;
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + PW'(1);
        end
    end

    // left and diagonal carry during fill, left and top capture in traceback
    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
        begin
            left_reg <= wdata;
            diag_reg <= top_v;
        end
        if (cmd.cap_left) left_reg <= score_rd_reg;
        if (cmd.cap_top)  top_reg  <= score_rd_reg;
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe <= 1'b0;
        end
        else
        begin
            strobe <= cmd.emit || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            a_symbol   <= path_rd_reg[7:0];
            b_symbol   <= path_rd_reg[15:8];
            a_gap      <= path_rd_reg[16];
            b_gap      <= path_rd_reg[17];
            best_score <= best_reg;
            empty_res  <= 1'b0;
            last       <= (k_reg == n_reg - PW'(1));
        end
        else if (cmd.emit_empty)
        begin
            a_symbol   <= '0;
            b_symbol   <= '0;
            a_gap      <= 1'b0;
            b_gap      <= 1'b0;
            best_score <= '0;
            empty_res  <= 1'b1;
            last       <= 1'b1;
        end
    end

    // status, a cell on the border row or column scores zero
    assign sts.no_cells  = (len_a_reg == '0) || (len_b_reg == '0);
    assign sts.fill_last = (i_reg == len_b_reg) && (j_reg == len_a_reg);
    assign sts.best_zero = (best_reg == '0);
    assign sts.cur_zero  = (score_rd_reg == '0) || (i_reg == '0) || (j_reg == '0);
    assign sts.out_last  = (k_reg == n_reg - PW'(1));

endmodule

`default_nettype wire

>>> rtl/core/lsa_checker.sv
// lsa_checker: port-level assertions for the aligner core, bound to the top level
// depends on lsa_pkg for the action codes
`default_nettype none

module lsa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] action,
    input wire logic       strobe,
    input wire logic       a_gap,
    input wire logic       b_gap,
    input wire logic [8:0] best_score,
    input wire logic       empty_res,
    input wire logic       last
);
    import lsa_pkg::*;

    // a column never has gaps on both sides
    a_one_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(a_gap && b_gap))
        else $error("column with gaps in both sequences");

    // an empty result is the whole run and carries no score
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && empty_res |-> last && best_score == 9'd0)
        else $error("empty result malformed");

    // a real column carries a positive score
    a_score: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !empty_res |-> best_score != 9'd0)
        else $error("column with zero best score");

    // an accepted align beat keeps the block busy
    a_align_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_ALIGN |=> busy)
        else $error("align not started");

endmodule

bind local_sequence_aligner_core lsa_checker u_lsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .strobe     (strobe),
    .a_gap      (a_gap),
    .b_gap      (b_gap),
    .best_score (best_score),
    .empty_res  (empty_res),
    .last       (last)
);

`default_nettype wire
